[hw/rtl/thahc_pkg.sv]
// Shared constants, register codes and preset values for the turret and hood controller.
package thahc_pkg;

   localparam int ANGLE_WIDTH_DEFAULT     = 24;
   localparam int POWER_FRAC_BITS_DEFAULT = 12;

   localparam int GAIN_WIDTH = 18;
   localparam int GAIN_SHIFT = 16;

   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int REG_INDEX_WIDTH = 3;

   localparam logic [REG_INDEX_WIDTH-1:0] REG_TURRET_GAIN   = 3'd0;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_HOOD_GAIN     = 3'd1;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_TURRET_MANUAL = 3'd2;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_HOOD_MANUAL   = 3'd3;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_FENDER        = 3'd4;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_IDLE          = 3'd5;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_LAUNCH        = 3'd6;
   localparam logic [REG_INDEX_WIDTH-1:0] REG_TARMAC        = 3'd7;

   // slots of the gain and power register arrays
   localparam int GAIN_COUNT  = 2;
   localparam int GAIN_TURRET = 0;
   localparam int GAIN_HOOD   = 1;

   localparam int POWER_COUNT         = 6;
   localparam int PWR_TURRET_MANUAL   = 0;
   localparam int PWR_HOOD_MANUAL     = 1;
   localparam int PWR_FENDER          = 2;
   localparam int PWR_IDLE            = 3;
   localparam int PWR_LAUNCH          = 4;
   localparam int PWR_TARMAC          = 5;

   localparam logic [GAIN_WIDTH-1:0] TURRET_GAIN_RESET = 18'd31457;
   localparam logic [GAIN_WIDTH-1:0] HOOD_GAIN_RESET   = 18'd155713;

   localparam int DPAD_WIDTH = 3;
   localparam logic [DPAD_WIDTH-1:0] DPAD_CENTRE = 3'd0;
   localparam logic [DPAD_WIDTH-1:0] DPAD_UP     = 3'd1;
   localparam logic [DPAD_WIDTH-1:0] DPAD_RIGHT  = 3'd2;
   localparam logic [DPAD_WIDTH-1:0] DPAD_DOWN   = 3'd3;
   localparam logic [DPAD_WIDTH-1:0] DPAD_LEFT   = 3'd4;

   localparam int TURRET_BAND        = 256;
   localparam int HOOD_BAND          = 200;
   localparam int TURRET_PRESET_DOWN = 8960;
   localparam int HOOD_PRESET_DOWN   = 16000;
   localparam int HOOD_PRESET_LEFT   = 12000;

endpackage

[hw/rtl/thahc_csr.sv]
// Configuration register file: gains, manual powers and shooter presets behind the APB port.
module thahc_csr #(
   parameter int POWER_FRAC_BITS = thahc_pkg::POWER_FRAC_BITS_DEFAULT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     csr_psel,
   input  logic                                     csr_penable,
   input  logic                                     csr_pwrite,
   input  logic [thahc_pkg::CSR_ADDR_WIDTH-1:0]     csr_paddr,
   input  logic [thahc_pkg::CSR_DATA_WIDTH-1:0]     csr_pwdata,
   output logic [thahc_pkg::CSR_DATA_WIDTH-1:0]     csr_prdata,
   output logic                                     csr_pready,
   output logic [thahc_pkg::GAIN_COUNT-1:0][thahc_pkg::GAIN_WIDTH-1:0] gain_o,
   output logic [thahc_pkg::POWER_COUNT-1:0][POWER_FRAC_BITS:0]        power_o
);

   localparam int PW                  = POWER_FRAC_BITS + 1;
   localparam int FULL_POWER          = 1 << POWER_FRAC_BITS;
   localparam int TURRET_MANUAL_RESET = (3 * FULL_POWER + 5) / 10;
   localparam int HOOD_MANUAL_RESET   = FULL_POWER / 2;

   localparam logic [thahc_pkg::GAIN_COUNT-1:0][thahc_pkg::GAIN_WIDTH-1:0] GAIN_RESET =
      {thahc_pkg::HOOD_GAIN_RESET, thahc_pkg::TURRET_GAIN_RESET};
   localparam logic [thahc_pkg::POWER_COUNT-1:0][PW-1:0] POWER_RESET =
      {PW'(0), PW'(0), PW'(0), PW'(0), PW'(HOOD_MANUAL_RESET), PW'(TURRET_MANUAL_RESET)};

   logic [thahc_pkg::GAIN_COUNT-1:0][thahc_pkg::GAIN_WIDTH-1:0] gain_ff, gain_in;
   logic [thahc_pkg::POWER_COUNT-1:0][PW-1:0]                   power_ff, power_in;
   logic [thahc_pkg::REG_INDEX_WIDTH-1:0] index;
   logic                                  write;
   logic [PW-1:0]                         wr_power;
   logic [PW-1:0]                         wr_power_sat;

   assign csr_pready   = 1'b1;
   assign index        = csr_paddr[thahc_pkg::CSR_ADDR_WIDTH-1:2];
   assign write        = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign wr_power     = csr_pwdata[PW-1:0];
   assign wr_power_sat = (wr_power > PW'(FULL_POWER)) ? PW'(FULL_POWER) : wr_power;

   always_comb begin
      gain_in  = gain_ff;
      power_in = power_ff;
      if (write) begin
         unique case (index)
            thahc_pkg::REG_TURRET_GAIN:
               gain_in[thahc_pkg::GAIN_TURRET] = csr_pwdata[thahc_pkg::GAIN_WIDTH-1:0];
            thahc_pkg::REG_HOOD_GAIN:
               gain_in[thahc_pkg::GAIN_HOOD] = csr_pwdata[thahc_pkg::GAIN_WIDTH-1:0];
            thahc_pkg::REG_TURRET_MANUAL: power_in[thahc_pkg::PWR_TURRET_MANUAL] = wr_power_sat;
            thahc_pkg::REG_HOOD_MANUAL:   power_in[thahc_pkg::PWR_HOOD_MANUAL]   = wr_power_sat;
            thahc_pkg::REG_FENDER:        power_in[thahc_pkg::PWR_FENDER]        = wr_power_sat;
            thahc_pkg::REG_IDLE:          power_in[thahc_pkg::PWR_IDLE]          = wr_power_sat;
            thahc_pkg::REG_LAUNCH:        power_in[thahc_pkg::PWR_LAUNCH]        = wr_power_sat;
            thahc_pkg::REG_TARMAC:        power_in[thahc_pkg::PWR_TARMAC]        = wr_power_sat;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         power_ff <= POWER_RESET;
      end else begin
         gain_ff  <= gain_in;
         power_ff <= power_in;
      end
   end

   always_comb begin
      unique case (index)
         thahc_pkg::REG_TURRET_GAIN:
            csr_prdata = thahc_pkg::CSR_DATA_WIDTH'(gain_ff[thahc_pkg::GAIN_TURRET]);
         thahc_pkg::REG_HOOD_GAIN:
            csr_prdata = thahc_pkg::CSR_DATA_WIDTH'(gain_ff[thahc_pkg::GAIN_HOOD]);
         thahc_pkg::REG_TURRET_MANUAL:
            csr_prdata = thahc_pkg::CSR_DATA_WIDTH'(power_ff[thahc_pkg::PWR_TURRET_MANUAL]);
         thahc_pkg::REG_HOOD_MANUAL:
            csr_prdata = thahc_pkg::CSR_DATA_WIDTH'(power_ff[thahc_pkg::PWR_HOOD_MANUAL]);
         thahc_pkg::REG_FENDER:
            csr_prdata = thahc_pkg::CSR_DATA_WIDTH'(power_ff[thahc_pkg::PWR_FENDER]);
         thahc_pkg::REG_IDLE:
            csr_prdata = thahc_pkg::CSR_DATA_WIDTH'(power_ff[thahc_pkg::PWR_IDLE]);
         thahc_pkg::REG_LAUNCH:
            csr_prdata = thahc_pkg::CSR_DATA_WIDTH'(power_ff[thahc_pkg::PWR_LAUNCH]);
         thahc_pkg::REG_TARMAC:
            csr_prdata = thahc_pkg::CSR_DATA_WIDTH'(power_ff[thahc_pkg::PWR_TARMAC]);
      endcase
   end

   assign gain_o  = gain_ff;
   assign power_o = power_ff;

endmodule

[hw/rtl/thahc_axis.sv]
// One axis drive law: stick override, clamped proportional power, tolerance band and hold.
module thahc_axis #(
   parameter int ANGLE_WIDTH     = thahc_pkg::ANGLE_WIDTH_DEFAULT,
   parameter int POWER_FRAC_BITS = thahc_pkg::POWER_FRAC_BITS_DEFAULT
) (
   input  logic signed [POWER_FRAC_BITS+1:0]      stick_i,
   input  logic signed [ANGLE_WIDTH-1:0]          meas_i,
   input  logic signed [ANGLE_WIDTH-1:0]          goal_i,
   input  logic signed [ANGLE_WIDTH-1:0]          err_pos_i,
   input  logic signed [ANGLE_WIDTH-1:0]          err_neg_i,
   input  logic signed [POWER_FRAC_BITS+1:0]      drive_i,
   input  logic [thahc_pkg::GAIN_WIDTH-1:0]       gain_i,
   input  logic [POWER_FRAC_BITS:0]               manual_i,
   input  logic [POWER_FRAC_BITS:0]               max_power_i,
   input  logic [ANGLE_WIDTH-1:0]                 tolerance_i,
   output logic signed [POWER_FRAC_BITS+1:0]      drive_o,
   output logic signed [ANGLE_WIDTH-1:0]          goal_o
);

   localparam int SW         = POWER_FRAC_BITS + 2;
   localparam int UW         = POWER_FRAC_BITS + 1;
   localparam int EW         = ANGLE_WIDTH + 1;
   localparam int PRODW      = EW + thahc_pkg::GAIN_WIDTH;
   localparam int MAGW       = PRODW - thahc_pkg::GAIN_SHIFT;
   localparam int FULL_POWER = 1 << POWER_FRAC_BITS;
   localparam int DEADBAND   = FULL_POWER / 2;
   localparam int MIN_POWER  = (7 * FULL_POWER + 50) / 100;

   localparam logic signed [SW-1:0] DB_HI = SW'(DEADBAND);
   localparam logic signed [SW-1:0] DB_LO = SW'(-DEADBAND);

   logic signed [EW-1:0]    err;
   logic [EW-1:0]           aerr;
   logic [PRODW-1:0]        product;
   logic [MAGW-1:0]         mag;
   logic [UW-1:0]           mag_clamp;
   logic [UW-1:0]           mag_offset;
   logic signed [SW-1:0]    prop_drive;
   logic signed [SW-1:0]    manual_s;
   logic                    stick_hi;
   logic                    stick_lo;

   assign err        = {err_pos_i[ANGLE_WIDTH-1], err_pos_i} - {err_neg_i[ANGLE_WIDTH-1], err_neg_i};
   assign aerr       = err[EW-1] ? EW'(-err) : EW'(err);
   assign product    = PRODW'(aerr) * PRODW'(gain_i);
   assign mag        = product[PRODW-1:thahc_pkg::GAIN_SHIFT];
   assign mag_clamp  = (mag > MAGW'(max_power_i)) ? max_power_i : mag[UW-1:0];
   assign mag_offset = mag_clamp + UW'(MIN_POWER);
   assign prop_drive = err[EW-1] ? -$signed({1'b0, mag_offset}) : $signed({1'b0, mag_offset});
   assign manual_s   = $signed({1'b0, manual_i});
   assign stick_hi   = stick_i > DB_HI;
   assign stick_lo   = stick_i < DB_LO;

   always_comb begin
      goal_o = goal_i;
      priority if (stick_hi) begin
         drive_o = manual_s;
         goal_o  = meas_i;
      end else if (stick_lo) begin
         drive_o = -manual_s;
         goal_o  = meas_i;
      end else if (aerr > EW'(tolerance_i)) begin
         // a zero proportional term outside the band keeps the previous drive
         drive_o = (mag != '0) ? prop_drive : drive_i;
      end else begin
         drive_o = '0;
      end
   end

endmodule

[hw/rtl/two_axis_turret_hood_controller.sv]
// Top level of the turret and hood controller: input register, target logic, axis drives, state.
//
//   port group   direction   transfer content
//   req_*        in          one control tick: buttons, sticks, d-pad, measured and vision angles
//   rsp_*        out         turret, hood and shooter powers, turret and hood targets
//   csr_*        in/out      gains, manual powers and shooter presets
//
// A tick is held in the input register; its result is registered in the state registers.
// Throughput: one tick per cycle unless rsp stalls; the path is one 25x18 multiply per axis.
// Reset clears the targets, drives, shooter power and preset arming; registers take defaults.
// An rsp stall holds the result; req stays ready until a tick waits behind a stalled result.
module two_axis_turret_hood_controller #(
   parameter int ANGLE_WIDTH     = thahc_pkg::ANGLE_WIDTH_DEFAULT,
   parameter int POWER_FRAC_BITS = thahc_pkg::POWER_FRAC_BITS_DEFAULT,
   localparam int IN_BITS  = 2 + 2 * (POWER_FRAC_BITS + 2) + thahc_pkg::DPAD_WIDTH
                             + 3 * ANGLE_WIDTH,
   localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
   localparam int OUT_BITS = 2 * (POWER_FRAC_BITS + 2) + (POWER_FRAC_BITS + 1) + 2 * ANGLE_WIDTH,
   localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // home_button, aim_button, stick_x, stick_y, dpad, turret_angle, hood_angle, vision_angle
   input  logic [IN_W-1:0]                      req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // turret drive, hood drive, shooter power, turret target, hood target
   output logic [OUT_W-1:0]                     rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [thahc_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [thahc_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [thahc_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                 csr_pready
);

   localparam int A   = ANGLE_WIDTH;
   localparam int SW  = POWER_FRAC_BITS + 2;
   localparam int UW  = POWER_FRAC_BITS + 1;
   localparam int DW  = thahc_pkg::DPAD_WIDTH;

   localparam int FULL_POWER = 1 << POWER_FRAC_BITS;
   localparam int TURRET_MAX = (3 * FULL_POWER + 5) / 10;
   localparam int HOOD_MAX   = FULL_POWER / 2;

   localparam int OFS_HOME   = 0;
   localparam int OFS_AIM    = 1;
   localparam int OFS_SX     = 2;
   localparam int OFS_SY     = OFS_SX + SW;
   localparam int OFS_DPAD   = OFS_SY + SW;
   localparam int OFS_TANG   = OFS_DPAD + DW;
   localparam int OFS_HANG   = OFS_TANG + A;
   localparam int OFS_VANG   = OFS_HANG + A;

   localparam logic signed [A-1:0] ANGLE_MAX = {1'b0, {(A - 1){1'b1}}};
   localparam logic signed [A-1:0] ANGLE_MIN = {1'b1, {(A - 1){1'b0}}};
   localparam logic signed [SW-1:0] POWER_HI = SW'(FULL_POWER);
   localparam logic signed [SW-1:0] POWER_LO = SW'(-FULL_POWER);

   logic [thahc_pkg::GAIN_COUNT-1:0][thahc_pkg::GAIN_WIDTH-1:0] gain;
   logic [thahc_pkg::POWER_COUNT-1:0][UW-1:0]                   power;

   logic               in_valid_ff, in_valid_in;
   logic [IN_BITS-1:0] in_data_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               req_accept;
   logic               fire;

   logic signed [A-1:0]  turret_goal_ff, turret_goal_in;
   logic signed [A-1:0]  hood_goal_ff, hood_goal_in;
   logic                 armed_ff, armed_in;
   logic signed [SW-1:0] turret_drive_ff, turret_drive_in;
   logic signed [SW-1:0] hood_drive_ff, hood_drive_in;
   logic [UW-1:0]        flywheel_ff, flywheel_in;

   logic                 home;
   logic                 aim;
   logic signed [SW-1:0] stick_x;
   logic signed [SW-1:0] stick_y;
   logic [DW-1:0]        dpad;
   logic signed [A-1:0]  turret_angle;
   logic signed [A-1:0]  hood_angle;
   logic signed [A-1:0]  vision_angle;

   logic signed [A:0]    aim_sum;
   logic signed [A-1:0]  aim_goal;
   logic signed [A-1:0]  turret_goal_a;
   logic signed [A-1:0]  turret_goal_b;
   logic signed [A-1:0]  hood_goal_b;
   logic                 armed_now;
   logic                 preset_hit;

   thahc_csr #(
      .POWER_FRAC_BITS(POWER_FRAC_BITS)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .gain_o      (gain),
      .power_o     (power)
   );

   // handshake: one input register stage, results live in the state registers
   assign req_accept   = req_tvalid & req_tready;
   assign fire         = in_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready   = ~in_valid_ff | fire;
   assign in_valid_in  = req_accept | (in_valid_ff & ~fire);
   assign rsp_valid_in = fire | (rsp_valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_tdata[IN_BITS-1:0];
      end
   end

   assign home         = in_data_ff[OFS_HOME];
   assign aim          = in_data_ff[OFS_AIM];
   assign stick_x      = $signed(in_data_ff[OFS_SX +: SW]);
   assign stick_y      = $signed(in_data_ff[OFS_SY +: SW]);
   assign dpad         = in_data_ff[OFS_DPAD +: DW];
   assign turret_angle = $signed(in_data_ff[OFS_TANG +: A]);
   assign hood_angle   = $signed(in_data_ff[OFS_HANG +: A]);
   assign vision_angle = $signed(in_data_ff[OFS_VANG +: A]);

   // target changes: home, then aim (aim wins over home), then an armed d-pad preset
   assign aim_sum = {turret_angle[A-1], turret_angle} + {vision_angle[A-1], vision_angle};

   always_comb begin
      if (aim_sum[A] != aim_sum[A-1]) begin
         aim_goal = aim_sum[A] ? ANGLE_MIN : ANGLE_MAX;
      end else begin
         aim_goal = aim_sum[A-1:0];
      end
   end

   always_comb begin
      priority if (aim) begin
         turret_goal_a = aim_goal;
      end else if (home) begin
         turret_goal_a = '0;
      end else begin
         turret_goal_a = turret_goal_ff;
      end
   end

   assign armed_now = armed_ff | (dpad == thahc_pkg::DPAD_CENTRE);

   always_comb begin
      turret_goal_b = turret_goal_a;
      hood_goal_b   = hood_goal_ff;
      flywheel_in   = flywheel_ff;
      armed_in      = armed_now;
      preset_hit    = 1'b0;
      if (armed_now) begin
         unique case (dpad)
            thahc_pkg::DPAD_UP: begin
               hood_goal_b   = '0;
               turret_goal_b = '0;
               flywheel_in   = power[thahc_pkg::PWR_FENDER];
               armed_in      = 1'b0;
               preset_hit    = 1'b1;
            end
            thahc_pkg::DPAD_RIGHT: begin
               hood_goal_b   = '0;
               turret_goal_b = '0;
               flywheel_in   = power[thahc_pkg::PWR_IDLE];
               armed_in      = 1'b0;
               preset_hit    = 1'b1;
            end
            thahc_pkg::DPAD_DOWN: begin
               hood_goal_b   = A'(thahc_pkg::HOOD_PRESET_DOWN);
               turret_goal_b = A'(thahc_pkg::TURRET_PRESET_DOWN);
               flywheel_in   = power[thahc_pkg::PWR_LAUNCH];
               armed_in      = 1'b0;
               preset_hit    = 1'b1;
            end
            thahc_pkg::DPAD_LEFT: begin
               hood_goal_b = A'(thahc_pkg::HOOD_PRESET_LEFT);
               flywheel_in = power[thahc_pkg::PWR_TARMAC];
               armed_in    = 1'b0;
               preset_hit  = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   thahc_axis #(
      .ANGLE_WIDTH     (ANGLE_WIDTH),
      .POWER_FRAC_BITS (POWER_FRAC_BITS)
   ) u_turret (
      .stick_i     (stick_x),
      .meas_i      (turret_angle),
      .goal_i      (turret_goal_b),
      .err_pos_i   (turret_goal_b),
      .err_neg_i   (turret_angle),
      .drive_i     (turret_drive_ff),
      .gain_i      (gain[thahc_pkg::GAIN_TURRET]),
      .manual_i    (power[thahc_pkg::PWR_TURRET_MANUAL]),
      .max_power_i (UW'(TURRET_MAX)),
      .tolerance_i (A'(thahc_pkg::TURRET_BAND)),
      .drive_o     (turret_drive_in),
      .goal_o      (turret_goal_in)
   );

   thahc_axis #(
      .ANGLE_WIDTH     (ANGLE_WIDTH),
      .POWER_FRAC_BITS (POWER_FRAC_BITS)
   ) u_hood (
      .stick_i     (stick_y),
      .meas_i      (hood_angle),
      .goal_i      (hood_goal_b),
      .err_pos_i   (hood_angle),
      .err_neg_i   (hood_goal_b),
      .drive_i     (hood_drive_ff),
      .gain_i      (gain[thahc_pkg::GAIN_HOOD]),
      .manual_i    (power[thahc_pkg::PWR_HOOD_MANUAL]),
      .max_power_i (UW'(HOOD_MAX)),
      .tolerance_i (A'(thahc_pkg::HOOD_BAND)),
      .drive_o     (hood_drive_in),
      .goal_o      (hood_goal_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         turret_goal_ff  <= '0;
         hood_goal_ff    <= '0;
         armed_ff        <= 1'b0;
         turret_drive_ff <= '0;
         hood_drive_ff   <= '0;
         flywheel_ff     <= '0;
      end else if (fire) begin
         turret_goal_ff  <= turret_goal_in;
         hood_goal_ff    <= hood_goal_in;
         armed_ff        <= armed_in;
         turret_drive_ff <= turret_drive_in;
         hood_drive_ff   <= hood_drive_in;
         flywheel_ff     <= flywheel_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = OUT_W'({hood_goal_ff, turret_goal_ff, flywheel_ff,
                               hood_drive_ff, turret_drive_ff});

`ifndef NO_ASSERTIONS
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a waiting tick behind a held result");

   a_preset_disarms: assert property (@(posedge clock) disable iff (reset)
      (fire && preset_hit) |=> !armed_ff)
      else $error("preset left the d-pad armed");

   a_drive_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (turret_drive_ff <= POWER_HI && turret_drive_ff >= POWER_LO &&
                      hood_drive_ff <= POWER_HI && hood_drive_ff >= POWER_LO))
      else $error("axis drive beyond full power");

   a_shooter_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (flywheel_ff <= UW'(FULL_POWER)))
      else $error("shooter power beyond full power");
`endif

endmodule
